/* design/zsev_pkg.sv */
// Package with the shared types, codes and CRC table of the stored ZIP entry verifier.
package zsev_pkg;

  // Width of the payload byte counter.
  localparam int LENGTH_BITS = 32;

  // Local header signature words and the store method code.
  localparam logic [15:0] SIG_PK       = 16'h4B50;
  localparam logic [15:0] SIG_LOCAL    = 16'h0403;
  localparam logic [15:0] METHOD_STORE = 16'h0000;

  // Item codes.
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVALID     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_INTEGRITY   = 2'd3;

  // CRC start value.
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // One input transaction.
  typedef struct packed {
    logic        opcode;
    logic [15:0] pk_signature;
    logic [15:0] header_signature;
    logic [15:0] compression_method;
    logic [15:0] general_flags;
    logic [31:0] expected_crc;
    logic [31:0] data_length;
    logic [7:0]  data_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] computed_crc;
  } out_item_t;

  // A result handed from the entry control to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // Reflected CRC-32 table for one nibble, polynomial 0xEDB88320.
  function automatic logic [31:0] nib_tab(input logic [3:0] idx);
    logic [31:0] val;
    case (idx)
      4'h0: val = 32'h00000000;
      4'h1: val = 32'h1DB71064;
      4'h2: val = 32'h3B6E20C8;
      4'h3: val = 32'h26D930AC;
      4'h4: val = 32'h76DC4190;
      4'h5: val = 32'h6B6B51F4;
      4'h6: val = 32'h4DB26158;
      4'h7: val = 32'h5005713C;
      4'h8: val = 32'hEDB88320;
      4'h9: val = 32'hF00F9344;
      4'hA: val = 32'hD6D6A3E8;
      4'hB: val = 32'hCB61B38C;
      4'hC: val = 32'h9B64C2B0;
      4'hD: val = 32'h86D3D2D4;
      4'hE: val = 32'hA00AE278;
      4'hF: val = 32'hBDBDF21C;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

/* design/zsev_crc_step.sv */
// Byte update of the reflected CRC-32 by two nibble table steps, low nibble first.
module zsev_crc_step import zsev_pkg::*; (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_new
);

  logic [31:0] crc_mid;

  // Low nibble step, then high nibble step.
  always_comb begin
    crc_mid = {4'h0, crc[31:4]} ^ nib_tab(crc[3:0] ^ data[3:0]);
    crc_new = {4'h0, crc_mid[31:4]} ^ nib_tab(crc_mid[3:0] ^ data[7:4]);
  end

endmodule

/* design/zsev_entry_ctrl.sv */
// Entry state of the verifier: header checks, byte counting and CRC accumulation.
module zsev_entry_ctrl import zsev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  in_item_t    cur,
  input  logic [15:0] supported_flags,
  output res_t        res
);

  logic [31:0]            crc_acc;
  logic [31:0]            crc_acc_next;
  logic [LENGTH_BITS-1:0] bytes_remaining;
  logic [LENGTH_BITS-1:0] bytes_remaining_next;
  logic [31:0]            crc_expected;
  logic [31:0]            crc_expected_next;
  logic                   receiving;
  logic                   receiving_next;
  logic [31:0]            crc_stepped;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic                   sig_bad;
  logic                   unsupp;

  zsev_crc_step u_crc_step (
    .crc     (crc_acc),
    .data    (cur.data_byte),
    .crc_new (crc_stepped)
  );

  // Header decode.
  assign hdr_len = cur.data_length[LENGTH_BITS-1:0];
  assign sig_bad = (cur.pk_signature != SIG_PK) || (cur.header_signature != SIG_LOCAL);
  assign unsupp  = (cur.compression_method != METHOD_STORE) ||
                   ((cur.general_flags & ~supported_flags) != 16'h0000);
  assign rem_dec = bytes_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  // Next state and result for the transaction in the input register.
  always_comb begin
    crc_acc_next         = crc_acc;
    bytes_remaining_next = bytes_remaining;
    crc_expected_next    = crc_expected;
    receiving_next       = receiving;
    res                  = '0;
    if (fire) begin
      if (cur.opcode == OP_HEADER) begin
        receiving_next = 1'b0;
        if (sig_bad) begin
          res.valid       = 1'b1;
          res.item.status = ST_INVALID;
        end else if (unsupp) begin
          res.valid       = 1'b1;
          res.item.status = ST_UNSUPPORTED;
        end else begin
          crc_acc_next         = CRC_INIT;
          crc_expected_next    = cur.expected_crc;
          bytes_remaining_next = hdr_len;
          if (hdr_len == '0) begin
            // Empty payload: the final CRC is the inverted start value.
            res.valid             = 1'b1;
            res.item.computed_crc = ~CRC_INIT;
            res.item.status       = (cur.expected_crc == ~CRC_INIT) ? ST_OK : ST_INTEGRITY;
          end else begin
            receiving_next = 1'b1;
          end
        end
      end else if (receiving) begin
        crc_acc_next         = crc_stepped;
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          receiving_next        = 1'b0;
          res.valid             = 1'b1;
          res.item.computed_crc = ~crc_stepped;
          res.item.status       = (~crc_stepped == crc_expected) ? ST_OK : ST_INTEGRITY;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc         <= CRC_INIT;
      bytes_remaining <= '0;
      crc_expected    <= '0;
      receiving       <= 1'b0;
    end else begin
      crc_acc         <= crc_acc_next;
      bytes_remaining <= bytes_remaining_next;
      crc_expected    <= crc_expected_next;
      receiving       <= receiving_next;
    end
  end

  // An entry in progress always has bytes left to count.
  a_recv_count: assert property (@(posedge clk) disable iff (rst)
    receiving |-> (bytes_remaining != '0))
    else $error("receiving with zero bytes remaining");

  // A data byte while idle leaves the CRC untouched.
  a_idle_data: assert property (@(posedge clk) disable iff (rst)
    fire && (cur.opcode == OP_DATA) && !receiving |=> $stable(crc_acc))
    else $error("idle data byte changed the CRC");

  // Finishing an entry always reports a result.
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    receiving && !receiving_next && fire && (cur.opcode == OP_DATA) |-> res.valid)
    else $error("entry finished without a result");

endmodule

/* design/zsev_out_reg.sv */
// Result register that holds one result transaction until the consumer takes it.
module zsev_out_reg import zsev_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_t      res,
  input  logic      result_stall,
  output logic      result_valid,
  output out_item_t result
);

  // Valid flag: load on a new result, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload is loaded only with a new result.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      result <= res.item;
    end
  end

  // A new result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  // Header errors carry a zero CRC.
  a_err_crc_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result.status == ST_INVALID) || (result.status == ST_UNSUPPORTED))
    |-> (result.computed_crc == 32'h0))
    else $error("header error with nonzero CRC");

  // A stalled result stays on the port.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

endmodule

/* design/zip_stored_entry_verifier.sv */
// Top level of the stored ZIP entry verifier: input register, flag register and result path.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   item     | in        | item_valid/stall   | in_item_t (header or byte)
//   result   | out       | result_valid/stall | out_item_t (status, CRC)
//   cfg      | in        | cfg_valid/ready    | supported_flags, 16 bits
//
// One transaction per cycle is accepted while item_stall is low; each is processed when it
// leaves the input register, and its result is held in the output register the cycle after.
// The cycle is set by two chained 16-entry nibble table lookups in the CRC update.
// Reset (rst, synchronous) empties both registers and clears the entry state.
// A stalled result holds the input register, and item_stall rises only then.
module zip_stored_entry_verifier import zsev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        s1_valid;
  in_item_t    s1_item;
  logic        out_free;
  logic        advance;
  logic [15:0] supported_flags;
  res_t        res;

  // Handshake control.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign cfg_ready  = 1'b1;

  // Flag mask register.
  always_ff @(posedge clk) begin
    if (rst) begin
      supported_flags <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      supported_flags <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  zsev_entry_ctrl u_entry_ctrl (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .cur             (s1_item),
    .supported_flags (supported_flags),
    .res             (res)
  );

  zsev_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  // The input stalls only when a held transaction cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled without cause");

  // A held transaction is kept until it is processed.
  a_s1_keep: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("held transaction lost");

  // Results come only from processed transactions.
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> advance)
    else $error("result without a processed transaction");

endmodule
